[rtl/core/clt_pkg.sv]
// ---------------------------------------------------------------------------
// clt_pkg: shared types and constants of the character LCD text writer
// Holds item kind and geometry codes, register indexes, DDRAM address
// constants and the job record that travels from front to back.
// ---------------------------------------------------------------------------
package clt_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_COMMAND  = 2'd0;
    localparam logic [1:0] KIND_POSITION = 2'd1;
    localparam logic [1:0] KIND_CHAR     = 2'd2;

    // Display geometries
    localparam logic [1:0] GEO_16X2 = 2'd0;
    localparam logic [1:0] GEO_20X4 = 2'd1;
    localparam logic [1:0] GEO_40X4 = 2'd2;

    // Configuration register indexes
    localparam logic REG_GEOMETRY = 1'b0;
    localparam logic REG_NIBBLE   = 1'b1;

    // Configuration port
    localparam int AddrWidth = 3;
    localparam int DataWidth = 32;

    // DDRAM addressing
    localparam logic [7:0] DDRAM_CMD      = 8'h80;
    localparam logic [6:0] ROW_ODD_OFFSET = 7'd64;
    localparam logic [6:0] ROW2_OFFSET_20 = 7'd20;
    localparam logic [6:0] ROW3_OFFSET_20 = 7'd84;
    localparam logic [5:0] LIMIT_20       = 6'd20;
    localparam logic [5:0] LIMIT_40       = 6'd40;
    localparam logic [7:0] LONG_WAIT_BELOW = 8'd4;

    // Job queue between front and back
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    // One item as bytes to send: optional address command, then the main byte
    typedef struct packed {
        logic       has_pre;
        logic [7:0] pre_byte;
        logic       pre_en;
        logic       rs;
        logic [7:0] main_byte;
        logic       en;
        logic       lw;
    } clt_job_t;

    // DDRAM address for a 20x4 wrap from the given row
    function automatic logic [6:0] wrap_addr_20(input logic [1:0] r);
        logic [6:0] a;
        case (r)
            2'd0:    a = ROW_ODD_OFFSET;
            2'd1:    a = ROW2_OFFSET_20;
            2'd2:    a = ROW3_OFFSET_20;
            default: a = 7'd0;
        endcase
        return a;
    endfunction

endpackage

[rtl/core/clt_front.sv]
// ---------------------------------------------------------------------------
// clt_front: item classifier and cursor tracker
// Accepts input items, keeps row, column and active controller, and turns
// each item of a known kind into one job for the transfer back end.
// ---------------------------------------------------------------------------
module clt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          geometry,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [7:0]          s_byte_value,
    input  logic [1:0]          s_row,
    input  logic [5:0]          s_column,
    input  logic                s_controller,
    input  logic                q_full,
    output logic                q_push,
    output clt_pkg::clt_job_t   q_job
);
    import clt_pkg::*;

    logic [1:0] row_reg, row_next;
    logic [5:0] col_reg, col_next;
    logic       act_reg, act_next;
    logic [1:0] geo;
    logic       accept;
    logic       is_40;
    logic       wrap20, wrap40;
    logic [6:0] sum;
    logic [6:0] offset;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign geo     = (geometry == GEO_20X4 || geometry == GEO_40X4) ? geometry : GEO_16X2;
    assign is_40   = (geo == GEO_40X4);
    assign wrap20  = (geo == GEO_20X4) && (col_reg >= LIMIT_20);
    assign wrap40  = is_40 && (col_reg >= LIMIT_40);

    // Position address offset
    always_comb begin
        if (geo == GEO_20X4 && s_row[1]) begin
            offset = s_row[0] ? ROW3_OFFSET_20 : ROW2_OFFSET_20;
        end else begin
            offset = s_row[0] ? ROW_ODD_OFFSET : 7'd0;
        end
        sum = {1'b0, s_column} + offset;
    end

    // Classify item, build job, compute next cursor state
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        act_next = act_reg;
        q_push   = 1'b0;
        q_job    = '0;
        case (s_kind)
            KIND_COMMAND: begin
                act_next        = is_40 ? s_controller : 1'b0;
                q_push          = accept;
                q_job.rs        = 1'b0;
                q_job.main_byte = s_byte_value;
                q_job.en        = act_next;
                q_job.lw        = (s_byte_value < LONG_WAIT_BELOW);
            end
            KIND_POSITION: begin
                row_next        = s_row;
                col_next        = s_column;
                act_next        = is_40 ? s_row[1] : 1'b0;
                q_push          = accept;
                q_job.rs        = 1'b0;
                q_job.main_byte = DDRAM_CMD | {1'b0, sum};
                q_job.en        = act_next;
            end
            KIND_CHAR: begin
                q_push = accept;
                if (wrap20) begin
                    q_job.has_pre  = 1'b1;
                    q_job.pre_byte = DDRAM_CMD | {1'b0, wrap_addr_20(row_reg)};
                    q_job.pre_en   = 1'b0;
                    row_next       = row_reg + 2'd1;
                    act_next       = 1'b0;
                    col_next       = 6'd1;
                end else if (wrap40) begin
                    q_job.has_pre  = 1'b1;
                    q_job.pre_byte = DDRAM_CMD | (row_reg[0] ? 8'd0 : {1'b0, ROW_ODD_OFFSET});
                    act_next       = row_reg[0] ^ row_reg[1];
                    q_job.pre_en   = act_next;
                    row_next       = row_reg + 2'd1;
                    col_next       = 6'd1;
                end else begin
                    col_next = col_reg + 6'd1;
                end
                q_job.rs        = 1'b1;
                q_job.main_byte = s_byte_value;
                q_job.en        = is_40 ? act_next : 1'b0;
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

    // Commit cursor state on accepted items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            act_reg <= 1'b0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
            act_reg <= act_next;
        end
    end

endmodule

[rtl/core/clt_queue.sv]
// ---------------------------------------------------------------------------
// clt_queue: job queue
// Short FIFO that decouples the classifier from the transfer sequencer.
// ---------------------------------------------------------------------------
module clt_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  clt_pkg::clt_job_t   push_job,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output clt_pkg::clt_job_t   head_job
);
    import clt_pkg::*;

    clt_job_t             mem_reg [QueueDepth];
    logic [QueueAw-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QueueAw-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QueueAw:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == QueueDepth[QueueAw:0]);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store jobs
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/core/clt_back.sv]
// ---------------------------------------------------------------------------
// clt_back: bus transfer sequencer
// Takes jobs from the queue and emits one bus transfer per beat, splitting
// bytes into high and low nibbles in four-bit mode.
// ---------------------------------------------------------------------------
module clt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                nibble_mode,
    input  logic                q_not_empty,
    input  clt_pkg::clt_job_t   q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_register_select,
    output logic [7:0]          m_bus_value,
    output logic                m_enable_select,
    output logic                m_long_wait,
    output logic                m_last
);
    import clt_pkg::*;

    clt_job_t   job_reg, job_next;
    logic       busy_reg, busy_next;
    logic       sel_pre_reg, sel_pre_next;
    logic       half_reg, half_next;
    logic       out_valid_reg, out_valid_next;
    logic       rs_reg, rs_next;
    logic [7:0] bus_reg, bus_next;
    logic       en_reg, en_next;
    logic       lw_reg, lw_next;
    logic       last_reg, last_next;

    logic       out_free;
    logic       fire;
    logic [7:0] cur_byte;
    logic       byte_done;
    logic       cur_last;

    assign out_free  = !out_valid_reg || m_ready;
    assign fire      = busy_reg && out_free;
    assign cur_byte  = sel_pre_reg ? job_reg.pre_byte : job_reg.main_byte;
    assign byte_done = !nibble_mode || half_reg;
    assign cur_last  = !sel_pre_reg && byte_done;

    // Sequence transfers and reload from the queue
    always_comb begin
        job_next       = job_reg;
        busy_next      = busy_reg;
        sel_pre_next   = sel_pre_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg && !m_ready;
        rs_next        = rs_reg;
        bus_next       = bus_reg;
        en_next        = en_reg;
        lw_next        = lw_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;

        // Emit current transfer
        if (fire) begin
            out_valid_next = 1'b1;
            rs_next        = sel_pre_reg ? 1'b0 : job_reg.rs;
            en_next        = sel_pre_reg ? job_reg.pre_en : job_reg.en;
            if (!nibble_mode) begin
                bus_next = cur_byte;
            end else if (!half_reg) begin
                bus_next = {cur_byte[7:4], 4'h0};
            end else begin
                bus_next = {cur_byte[3:0], 4'h0};
            end
            lw_next   = cur_last && job_reg.lw;
            last_next = cur_last;
            if (byte_done) begin
                half_next    = 1'b0;
                sel_pre_next = 1'b0;
                if (cur_last) begin
                    busy_next = 1'b0;
                end
            end else begin
                half_next = 1'b1;
            end
        end

        // Load next job
        if (!busy_next && q_not_empty) begin
            q_pop        = 1'b1;
            job_next     = q_head;
            busy_next    = 1'b1;
            sel_pre_next = q_head.has_pre;
            half_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            sel_pre_reg   <= 1'b0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            sel_pre_reg   <= sel_pre_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        rs_reg   <= rs_next;
        bus_reg  <= bus_next;
        en_reg   <= en_next;
        lw_reg   <= lw_next;
        last_reg <= last_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_register_select = rs_reg;
    assign m_bus_value       = bus_reg;
    assign m_enable_select   = en_reg;
    assign m_long_wait       = lw_reg;
    assign m_last            = last_reg;

endmodule

[rtl/core/char_lcd_text_writer.sv]
// ---------------------------------------------------------------------------
// char_lcd_text_writer: HD44780 character LCD text writer
// Turns command, position and character items into LCD bus transfers.
// ---------------------------------------------------------------------------
// An item passes a queue entry and the sequencer job and output registers.
// Throughput: one transfer per cycle while m_ready is high and jobs wait; an
// item costs 1 to 4 transfers (wrap command plus character, two nibbles each).
// Input takes an item per cycle while the four-entry job queue has room.
// Reset: synchronous, active low; cursor at row 0 column 0, controller 0,
// geometry 16x2, four-bit bus.
module char_lcd_text_writer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [clt_pkg::AddrWidth-1:0]    paddr,
    input  logic [clt_pkg::DataWidth-1:0]    pwdata,
    output logic [clt_pkg::DataWidth-1:0]    prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_kind,
    input  logic [7:0]                       s_byte_value,
    input  logic [1:0]                       s_row,
    input  logic [5:0]                       s_column,
    input  logic                             s_controller,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_register_select,
    output logic [7:0]                       m_bus_value,
    output logic                             m_enable_select,
    output logic                             m_long_wait,
    output logic                             m_last
);
    import clt_pkg::*;

    logic [1:0] geometry_reg;
    logic       nibble_reg;
    logic       cfg_write;
    logic       reg_index;
    logic       q_full, q_push, q_pop, q_not_empty;
    clt_job_t   q_job, q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[2];

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geometry_reg <= GEO_16X2;
            nibble_reg   <= 1'b1;
        end else if (cfg_write) begin
            case (reg_index)
                REG_GEOMETRY: geometry_reg <= pwdata[1:0];
                REG_NIBBLE:   nibble_reg   <= pwdata[0];
                default:      geometry_reg <= geometry_reg;
            endcase
        end
    end

    // Read back configuration
    always_comb begin
        case (reg_index)
            REG_GEOMETRY: prdata = {{(DataWidth-2){1'b0}}, geometry_reg};
            REG_NIBBLE:   prdata = {{(DataWidth-1){1'b0}}, nibble_reg};
            default:      prdata = '0;
        endcase
    end

    clt_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .geometry     (geometry_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_byte_value (s_byte_value),
        .s_row        (s_row),
        .s_column     (s_column),
        .s_controller (s_controller),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job)
    );

    clt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (q_head)
    );

    clt_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .nibble_mode       (nibble_reg),
        .q_not_empty       (q_not_empty),
        .q_head            (q_head),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_register_select (m_register_select),
        .m_bus_value       (m_bus_value),
        .m_enable_select   (m_enable_select),
        .m_long_wait       (m_long_wait),
        .m_last            (m_last)
    );

endmodule

[tb/tb_char_lcd_text_writer.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_char_lcd_text_writer: self-checking bench for the character LCD writer
// Drives command, position and character items across all display layouts
// and both bus widths, predicts every LCD bus transfer and compares each
// result beat field by field against the oldest predicted transfer.
// ---------------------------------------------------------------------------
import clt_pkg::*;

// One LCD bus transfer as seen on the result channel
typedef struct packed {
    logic       rs;
    logic [7:0] bus;
    logic       en;
    logic       lw;
    logic       last;
} lcd_xfer_t;

class lcd_bus_predictor;
    logic [1:0] geometry = GEO_16X2;
    logic       nibble   = 1'b1;
    logic [1:0] cur_row  = '0;
    logic [5:0] cur_col  = '0;
    logic       cur_ctl  = 1'b0;
    lcd_xfer_t  pending_xfers[$];
    int         errors   = 0;

    function void set_reg(logic idx, logic [31:0] val);
        if (idx == REG_GEOMETRY) begin
            geometry = val[1:0];
        end else begin
            nibble = val[0];
        end
    endfunction

    // Queue one byte as one full transfer or two nibble transfers
    function void push_byte(logic rs, logic [7:0] b, logic en, logic lw, logic last);
        if (nibble) begin
            pending_xfers.push_back('{rs, {b[7:4], 4'h0}, en, 1'b0, 1'b0});
            pending_xfers.push_back('{rs, {b[3:0], 4'h0}, en, lw, last});
        end else begin
            pending_xfers.push_back('{rs, b, en, lw, last});
        end
    endfunction

    // Predict the transfers of one accepted input beat
    function void note_item(logic [1:0] kind, logic [7:0] b, logic [1:0] row,
                            logic [5:0] col, logic ctl);
        logic [1:0] g;
        logic [6:0] sum;
        g = (geometry == GEO_20X4 || geometry == GEO_40X4) ? geometry : GEO_16X2;
        case (kind)
            KIND_COMMAND: begin
                cur_ctl = (g == GEO_40X4) ? ctl : 1'b0;
                push_byte(1'b0, b, cur_ctl, b < LONG_WAIT_BELOW, 1'b1);
            end
            KIND_POSITION: begin
                cur_row = row;
                cur_col = col;
                if (g == GEO_20X4 && row >= 2'd2) begin
                    sum = {1'b0, col} + ((row == 2'd2) ? ROW2_OFFSET_20 : ROW3_OFFSET_20);
                end else begin
                    sum = {1'b0, col} + (row[0] ? ROW_ODD_OFFSET : 7'd0);
                end
                cur_ctl = (g == GEO_40X4) ? row[1] : 1'b0;
                push_byte(1'b0, DDRAM_CMD | {1'b0, sum}, cur_ctl, 1'b0, 1'b1);
            end
            KIND_CHAR: begin
                // Wrap to the next row first where the layout has a column limit
                if (g == GEO_20X4 && cur_col >= LIMIT_20) begin
                    case (cur_row)
                        2'd0:    sum = ROW_ODD_OFFSET;
                        2'd1:    sum = ROW2_OFFSET_20;
                        2'd2:    sum = ROW3_OFFSET_20;
                        default: sum = 7'd0;
                    endcase
                    cur_row = cur_row + 2'd1;
                    cur_col = '0;
                    cur_ctl = 1'b0;
                    push_byte(1'b0, DDRAM_CMD | {1'b0, sum}, 1'b0, 1'b0, 1'b0);
                end else if (g == GEO_40X4 && cur_col >= LIMIT_40) begin
                    sum     = cur_row[0] ? 7'd0 : ROW_ODD_OFFSET;
                    cur_ctl = cur_row[0] ^ cur_row[1];
                    cur_row = cur_row + 2'd1;
                    cur_col = '0;
                    push_byte(1'b0, DDRAM_CMD | {1'b0, sum}, cur_ctl, 1'b0, 1'b0);
                end
                push_byte(1'b1, b, (g == GEO_40X4) ? cur_ctl : 1'b0, 1'b0, 1'b1);
                cur_col = cur_col + 6'd1;
            end
            default: ;
        endcase
    endfunction

    function void report(string what, lcd_xfer_t want, lcd_xfer_t got);
        errors++;
        if (errors <= 10) begin
            $display("%0t %s: expected rs=%0b bus=%02h en=%0b lw=%0b last=%0b,",
                     $realtime, what, want.rs, want.bus, want.en, want.lw, want.last);
            $display("    got rs=%0b bus=%02h en=%0b lw=%0b last=%0b",
                     got.rs, got.bus, got.en, got.lw, got.last);
        end
    endfunction

    // Compare one result beat against the oldest predicted transfer
    function void check_xfer(lcd_xfer_t got);
        lcd_xfer_t want;
        if (pending_xfers.size() == 0) begin
            report("unexpected transfer", '0, got);
            return;
        end
        want = pending_xfers.pop_front();
        if (got.rs !== want.rs || got.bus !== want.bus || got.en !== want.en ||
            got.lw !== want.lw || got.last !== want.last) begin
            report("transfer mismatch", want, got);
        end
    endfunction

    function int pending();
        return pending_xfers.size();
    endfunction
endclass

module tb_char_lcd_text_writer;

    localparam logic [1:0] KIND_NONE = 2'd3;   // unused kind, ignored by the block
    localparam int IdleLimit = 3000;
    localparam int HoldCycles = 300;
    localparam int SettleCycles = 8;

    logic                 aclk;
    logic                 aresetn      = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [AddrWidth-1:0] paddr        = '0;
    logic [DataWidth-1:0] pwdata       = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_kind       = '0;
    logic [7:0]           s_byte_value = '0;
    logic [1:0]           s_row        = '0;
    logic [5:0]           s_column     = '0;
    logic                 s_controller = 1'b0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic                 m_register_select;
    logic [7:0]           m_bus_value;
    logic                 m_enable_select;
    logic                 m_long_wait;
    logic                 m_last;

    lcd_bus_predictor sb = new();

    int         tx_idle_pct   = 0;
    int         rx_stall_pct  = 0;
    int         hold_request  = 0;
    int         hold_served   = 0;
    int         hold_left     = 0;
    int         idle_cycles   = 0;
    logic [1:0] tb_geometry   = GEO_16X2;

    char_lcd_text_writer i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_byte_value      (s_byte_value),
        .s_row             (s_row),
        .s_column          (s_column),
        .s_controller      (s_controller),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_register_select (m_register_select),
        .m_bus_value       (m_bus_value),
        .m_enable_select   (m_enable_select),
        .m_long_wait       (m_long_wait),
        .m_last            (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: hold off on request, otherwise stall at the phase's rate
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_served != hold_request) begin
            hold_served <= hold_request;
            hold_left   <= HoldCycles;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Predict on every accepted input beat
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_item(s_kind, s_byte_value, s_row, s_column, s_controller);
        end
    end

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_xfer('{m_register_select, m_bus_value, m_enable_select,
                            m_long_wait, m_last});
        end
    end

    // Watchdog: end the run after too long without any beat
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Register write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        if (idx == REG_GEOMETRY) begin
            tb_geometry = val[1:0];
        end
    endtask

    // Offer one item, with random idle cycles ahead of it
    task automatic send_item(input logic [1:0] kind, input logic [7:0] b,
                             input logic [1:0] row, input logic [5:0] col,
                             input logic ctl);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_byte_value <= b;
        s_row        <= row;
        s_column     <= col;
        s_controller <= ctl;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, let the last beat reach the predictor, wait for every
    // predicted transfer, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic send_char();
        send_item(KIND_CHAR, 8'($urandom), 2'($urandom), 6'($urandom), 1'($urandom));
    endtask

    // One random phase: mostly cursor placement followed by runs of characters
    task automatic run_phase(input logic [1:0] geo, input logic nib, input int tx_pct,
                             input int rx_pct, input bit hold, input int items);
        int n;
        int pick;
        int lim;
        int run;
        logic [5:0] col;
        drain();
        write_reg(REG_GEOMETRY, {30'd0, geo});
        write_reg(REG_NIBBLE, {31'd0, nib});
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        if (hold) begin
            hold_request <= hold_request + 1;
        end
        lim = (tb_geometry == GEO_20X4) ? 20 : (tb_geometry == GEO_40X4) ? 40 : 16;
        n = 0;
        while (n < items) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                col = $urandom_range(1) ? 6'($urandom_range(63))
                                        : 6'($urandom_range(lim, lim - 4));
                send_item(KIND_POSITION, 8'($urandom), 2'($urandom), col, 1'($urandom));
                n++;
                run = $urandom_range(6, 1);
                repeat (run) begin
                    send_char();
                    n++;
                end
            end else if (pick < 82) begin
                send_char();
                n++;
            end else if (pick < 95) begin
                send_item(KIND_COMMAND,
                          $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom),
                          2'($urandom), 6'($urandom), 1'($urandom));
                n++;
            end else begin
                send_item(KIND_NONE, 8'($urandom), 2'($urandom), 6'($urandom),
                          1'($urandom));
            end
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset layout 16x2 with four-bit bus: commands, odd-row offset, column wrap
        send_item(KIND_COMMAND, 8'h00, 2'd3, 6'd63, 1'b1);
        send_item(KIND_COMMAND, 8'h03, 2'd0, 6'd0, 1'b0);
        send_item(KIND_COMMAND, 8'h04, 2'd1, 6'd21, 1'b1);
        send_item(KIND_COMMAND, 8'hFF, 2'd2, 6'd42, 1'b0);
        send_item(KIND_POSITION, 8'hFF, 2'd3, 6'd63, 1'b1);
        send_item(KIND_CHAR, 8'hA5, 2'd0, 6'd0, 1'b0);
        send_item(KIND_CHAR, 8'h5A, 2'd3, 6'd63, 1'b1);
        send_item(KIND_NONE, 8'h77, 2'd1, 6'd5, 1'b1);
        drain();

        // 20x4 with eight-bit bus: row 2 to 3 wrap, column beyond limit, row 3 to 0
        write_reg(REG_GEOMETRY, {30'd0, GEO_20X4});
        write_reg(REG_NIBBLE, 32'd0);
        send_item(KIND_POSITION, 8'h00, 2'd2, 6'd19, 1'b0);
        send_item(KIND_CHAR, 8'h41, 2'd0, 6'd0, 1'b0);
        send_item(KIND_CHAR, 8'h42, 2'd0, 6'd0, 1'b0);
        send_item(KIND_POSITION, 8'h00, 2'd3, 6'd63, 1'b1);
        send_item(KIND_CHAR, 8'h43, 2'd0, 6'd0, 1'b0);
        send_item(KIND_POSITION, 8'h00, 2'd1, 6'd0, 1'b0);
        send_item(KIND_CHAR, 8'h00, 2'd0, 6'd0, 1'b0);
        drain();

        // 40x4 with four-bit bus: second controller, row 1 to 2 and row 3 to 0 wraps
        write_reg(REG_GEOMETRY, {30'd0, GEO_40X4});
        write_reg(REG_NIBBLE, 32'd1);
        send_item(KIND_COMMAND, 8'h01, 2'd0, 6'd0, 1'b1);
        send_item(KIND_POSITION, 8'h00, 2'd1, 6'd40, 1'b0);
        send_item(KIND_CHAR, 8'h61, 2'd0, 6'd0, 1'b0);
        send_item(KIND_POSITION, 8'h00, 2'd3, 6'd39, 1'b0);
        send_item(KIND_CHAR, 8'h62, 2'd0, 6'd0, 1'b0);
        send_item(KIND_CHAR, 8'h63, 2'd0, 6'd0, 1'b0);
        send_item(KIND_COMMAND, 8'h02, 2'd0, 6'd0, 1'b1);
        drain();

        // Unused geometry code acts as 16x2; the enable line drops to the first
        write_reg(REG_GEOMETRY, 32'd3);
        send_item(KIND_CHAR, 8'h7E, 2'd0, 6'd0, 1'b1);

        // Random phases; the first one holds off the receiver to fill the block
        run_phase(GEO_16X2, 1'b0, 0, 0, 1'b1, 11);
        run_phase(GEO_20X4, 1'b1, 83, 0, 1'b0, 11);
        run_phase(GEO_40X4, 1'b0, 0, 83, 1'b0, 11);
        run_phase(GEO_40X4, 1'b1, 17, 17, 1'b0, 11);
        run_phase(GEO_20X4, 1'b0, 0, 0, 1'b0, 11);
        run_phase(2'd3, 1'b1, 83, 0, 1'b0, 11);
        run_phase(GEO_16X2, 1'b1, 0, 83, 1'b0, 11);
        run_phase(GEO_40X4, 1'b0, 17, 17, 1'b0, 11);

        repeat (2 * SettleCycles) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/clt_pkg.sv
rtl/core/clt_front.sv
rtl/core/clt_queue.sv
rtl/core/clt_back.sv
rtl/core/char_lcd_text_writer.sv
tb/tb_char_lcd_text_writer.sv
